>>> design/text_escape_translator_macros.svh
// Assertion macros shared by the translator modules.
// Each check is sampled on the rising edge of clk_i.
`ifndef TEXT_ESCAPE_TRANSLATOR_MACROS_SVH
`define TEXT_ESCAPE_TRANSLATOR_MACROS_SVH

// Check that is switched off while reset is asserted.
`define TET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define TET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/tet_pkg.sv
`default_nettype none

package tet_pkg;

  // Characters with a special meaning, and the bytes that they produce.
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // Most result items that one input item can cause.
  localparam int unsigned MaxRes = 3;

  // Character held back while waiting for the next one.
  typedef enum logic [2:0] {
    PEND_NONE   = 3'd0,
    PEND_CARET  = 3'd1,
    PEND_TILDE  = 3'd2,
    PEND_BSLASH = 3'd3,
    PEND_PCT    = 3'd4
  } pend_e;

  // Group of result items caused by one input item.
  typedef struct packed {
    logic [1:0]             cnt;     // number of result items, 0 to 3
    logic [MaxRes-1:0][7:0] data;    // result bytes, first in slot 0
    logic                   marker;  // single end marker without a character
    logic                   eot;     // last item of the group ends the text
  } grp_t;

endpackage

`default_nettype wire

>>> design/tet_decode.sv
`default_nettype none

module tet_decode (
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  input  wire tet_pkg::pend_e pend_i,
  output tet_pkg::grp_t       grp_o,
  output tet_pkg::pend_e      pend_o
);

  always_comb begin
    logic [7:0]     lc;
    logic           used;
    logic [1:0]     n;
    tet_pkg::pend_e np;
    tet_pkg::grp_t  g;

    lc   = byte_i;
    used = 1'b0;
    n    = 2'd0;
    np   = tet_pkg::PEND_NONE;
    g    = '0;

    // Fold upper-case letters onto lower case for the escape letters.
    if (byte_i >= tet_pkg::CH_UP_A && byte_i <= tet_pkg::CH_UP_Z) begin
      lc = byte_i | tet_pkg::CASE_BIT;
    end

    // Resolve the character held from the previous item.
    case (pend_i)
      tet_pkg::PEND_CARET: begin
        if (byte_i == tet_pkg::CH_CARET) begin
          g.data[n] = tet_pkg::CH_CARET;
          used      = 1'b1;
        end else begin
          g.data[n] = tet_pkg::CH_ESC;
        end
        n = n + 2'd1;
      end
      tet_pkg::PEND_TILDE: begin
        if (byte_i == tet_pkg::CH_TILDE) begin
          g.data[n] = tet_pkg::CH_TILDE;
          n         = n + 2'd1;
          used      = 1'b1;
        end else begin
          g.data[n] = tet_pkg::CH_ESC;
          n         = n + 2'd1;
          g.data[n] = tet_pkg::CH_LBRACK;
          n         = n + 2'd1;
        end
      end
      tet_pkg::PEND_BSLASH: begin
        used = 1'b1;
        if (lc == tet_pkg::CH_LOW_R)      g.data[n] = tet_pkg::CH_CR;
        else if (lc == tet_pkg::CH_LOW_N) g.data[n] = tet_pkg::CH_LF;
        else if (lc == tet_pkg::CH_LOW_T) g.data[n] = tet_pkg::CH_TAB;
        else if (lc == tet_pkg::CH_LOW_A) g.data[n] = tet_pkg::CH_BEL;
        else if (lc == tet_pkg::CH_LOW_B) g.data[n] = tet_pkg::CH_BS;
        else                              g.data[n] = byte_i;
        n = n + 2'd1;
      end
      tet_pkg::PEND_PCT: begin
        used = 1'b1;
        if (lc == tet_pkg::CH_LOW_R)        g.data[n] = tet_pkg::CH_CR;
        else if (lc == tet_pkg::CH_LOW_N)   g.data[n] = tet_pkg::CH_LF;
        else if (lc == tet_pkg::CH_LOW_T)   g.data[n] = tet_pkg::CH_TAB;
        else if (byte_i == tet_pkg::CH_BANG) g.data[n] = tet_pkg::CH_SEMI;
        else begin
          g.data[n] = tet_pkg::CH_PCT;
          used      = 1'b0;
        end
        n = n + 2'd1;
      end
      default: begin
      end
    endcase

    // Handle the new character itself unless the escape consumed it.
    if (!used) begin
      if (byte_i == tet_pkg::CH_CARET)       np = tet_pkg::PEND_CARET;
      else if (byte_i == tet_pkg::CH_TILDE)  np = tet_pkg::PEND_TILDE;
      else if (byte_i == tet_pkg::CH_BSLASH) np = tet_pkg::PEND_BSLASH;
      else if (byte_i == tet_pkg::CH_PCT)    np = tet_pkg::PEND_PCT;
      else begin
        g.data[n] = byte_i;
        n         = n + 2'd1;
      end
    end

    // At the end of the text flush what is held; a held backslash is dropped.
    if (last_i) begin
      if (np == tet_pkg::PEND_CARET) begin
        g.data[n] = tet_pkg::CH_ESC;
        n         = n + 2'd1;
      end else if (np == tet_pkg::PEND_TILDE) begin
        g.data[n] = tet_pkg::CH_ESC;
        n         = n + 2'd1;
        g.data[n] = tet_pkg::CH_LBRACK;
        n         = n + 2'd1;
      end else if (np == tet_pkg::PEND_PCT) begin
        g.data[n] = tet_pkg::CH_PCT;
        n         = n + 2'd1;
      end
      np    = tet_pkg::PEND_NONE;
      g.eot = 1'b1;
      // An end with no character still gives one marker item.
      if (n == 2'd0) begin
        g.data   = '0;
        g.marker = 1'b1;
        n        = 2'd1;
      end
    end

    g.cnt  = n;
    grp_o  = g;
    pend_o = np;
  end

endmodule

`default_nettype wire

>>> design/tet_emit.sv
`default_nettype none

`include "text_escape_translator_macros.svh"

module tet_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_valid_i,
  input  wire tet_pkg::grp_t  grp_i,
  output logic                load_ready_o,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,  // [7:0] out_byte
  output logic                m_axis_tuser_o,  // [0] byte_valid
  output logic                m_axis_tlast_o   // end_of_text
);

  logic          valid_q, valid_d;
  logic [1:0]    idx_q, idx_d;
  tet_pkg::grp_t grp_q, grp_d;
  logic          final_beat;
  logic          beat;

  // The group register empties once its final item is taken.
  assign beat         = valid_q && m_axis_tready_i;
  assign final_beat   = beat && (idx_q == grp_q.cnt - 2'd1);
  assign load_ready_o = !valid_q || final_beat;

  // Load a new group or step through the current one.
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    grp_d   = grp_q;
    if (load_ready_o) begin
      valid_d = load_valid_i;
      idx_d   = 2'd0;
      grp_d   = grp_i;
    end else if (beat) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // The group payload needs no reset.
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // Present the current item of the group.
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = grp_q.data[idx_q];
  assign m_axis_tuser_o  = !grp_q.marker;
  assign m_axis_tlast_o  = grp_q.eot && (idx_q == grp_q.cnt - 2'd1);

  `TET_ASSERT(a_idx_in_group, valid_q |-> (idx_q < grp_q.cnt), "item index beyond group")
  `TET_ASSERT(a_marker_alone, (valid_q && grp_q.marker) |-> (grp_q.cnt == 2'd1 && grp_q.eot),
              "end marker not alone")
  `TET_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!valid_q && idx_q == 2'd0),
                     "group register not empty in reset")

endmodule

`default_nettype wire

>>> design/text_escape_translator.sv
// Channel   Direction  Ports                  Item
// s_axis    in         tdata, tlast           in_byte, last_byte
// m_axis    out        tdata, tuser, tlast    out_byte, byte_valid, end_of_text
//
// An item is registered on entry, decoded against the held character and
// placed as a group of up to three result items in the group register.
// One input item is taken per cycle while the group register can take its result;
// each group yields its result items one by one, and the input waits until its last item is taken.
// Reset clears the input register, the held character and the group register.
// A stalled output holds its item and the input stalls behind it.
`default_nettype none

`include "text_escape_translator_macros.svh"

module text_escape_translator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // last_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tuser_o,   // [0] byte_valid
  output logic            m_axis_tlast_o    // end_of_text
);

  logic           s1_valid_q, s1_valid_d;
  logic [7:0]     s1_byte_q, s1_byte_d;
  logic           s1_last_q, s1_last_d;
  tet_pkg::pend_e pend_q, pend_d;
  tet_pkg::pend_e pend_next;
  tet_pkg::grp_t  grp;
  logic           load_ready;
  logic           consume;

  // Input register advances whenever the group register can take its result.
  assign consume         = s1_valid_q && load_ready;
  assign s_axis_tready_o = !s1_valid_q || load_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_byte_d  = s1_byte_q;
    s1_last_d  = s1_last_q;
    pend_d     = pend_q;
    if (consume) begin
      pend_d = pend_next;
    end
    if (s_axis_tready_o) begin
      s1_valid_d = s_axis_tvalid_i;
      s1_byte_d  = s_axis_tdata_i;
      s1_last_d  = s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= tet_pkg::PEND_NONE;
    end else begin
      s1_valid_q <= s1_valid_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    s1_last_q <= s1_last_d;
  end

  // Escape decoding of the registered item.
  tet_decode u_decode (
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .pend_i (pend_q),
    .grp_o  (grp),
    .pend_o (pend_next)
  );

  // Group register and one-item-per-cycle output while the output is ready.
  tet_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_valid_i    (s1_valid_q && (grp.cnt != 2'd0)),
    .grp_i           (grp),
    .load_ready_o    (load_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `TET_ASSERT(a_nothing_held_after_end, (consume && s1_last_q) |=> (pend_q == tet_pkg::PEND_NONE),
              "character still held after end of text")
  `TET_ASSERT(a_input_holds, (s1_valid_q && !load_ready) |=> (s1_valid_q && $stable(s1_byte_q)),
              "input register changed while stalled")
  `TET_ASSERT(a_last_gives_result, (consume && s1_last_q) |-> (grp.cnt != 2'd0 && grp.eot),
              "end of text produced no result")

endmodule

`default_nettype wire
